// File: rtl/core/fipl_pkg.sv
// ----------------------------------------------------------------------------
// fipl_pkg
// shared types, codes and constants of the firmware image page loader
// ----------------------------------------------------------------------------
package fipl_pkg;

	localparam int unsigned PAGE_BYTES_DEF = 128;
	localparam logic [15:0] MAX_IMAGE_DEF  = 16'(32'h3800 * 2);
	localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
	localparam logic [15:0] APP_START      = 16'h0000;

	// register index of max_image_bytes
	localparam logic [0:0]  REG_MAX_IMAGE  = 1'b0;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE  = 2'd1,
		REQ_END   = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		K_FLASH = 2'd0,
		K_ACK   = 2'd1,
		K_NACK  = 2'd2,
		K_FINAL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE      = 2'd0,
		PH_READY     = 2'd1,
		PH_RECEIVING = 2'd2,
		PH_FINISHED  = 2'd3
	} phase_t;

	// what the latched item turns into
	typedef enum logic [1:0] {
		OC_NONE = 2'd0,
		OC_ONE  = 2'd1,
		OC_PAIR = 2'd2,
		OC_DUMP = 2'd3
	} outcome_t;

	typedef struct packed {
		outcome_t outcome;
		logic     last_word;
		logic     out_free;
	} dp_status_t;

	typedef struct packed {
		logic accept;
		logic commit;
		logic load_final;
		logic load_word;
	} dp_cmd_t;

endpackage

// File: rtl/core/fipl_item_if.sv
// ----------------------------------------------------------------------------
// fipl_item_if
// request channel: start request, payload byte or end of frame
// ----------------------------------------------------------------------------
interface fipl_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic       frame_is_data;
	logic [7:0] frame_length;
	logic [7:0] data_byte;

	modport source (output valid, req_type, frame_is_data, frame_length, data_byte,
		input ready);
	modport sink (input valid, req_type, frame_is_data, frame_length, data_byte,
		output ready);
endinterface

// File: rtl/core/fipl_result_if.sv
// ----------------------------------------------------------------------------
// fipl_result_if
// response channel: acks, nacks and flash word writes
// ----------------------------------------------------------------------------
interface fipl_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  resp_kind;
	logic        answers_request;
	logic [1:0]  state_code;
	logic [15:0] flash_address;
	logic [15:0] flash_word;
	logic        last;

	modport source (output valid, resp_kind, answers_request, state_code, flash_address,
		flash_word, last, input ready);
	modport sink (input valid, resp_kind, answers_request, state_code, flash_address,
		flash_word, last, output ready);
endinterface

// File: rtl/core/fipl_ram.sv
// ----------------------------------------------------------------------------
// fipl_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module fipl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/fipl_datapath.sv
// ----------------------------------------------------------------------------
// fipl_datapath
// loader state, page store in two byte banks and the result register
// ----------------------------------------------------------------------------
module fipl_datapath #(
	parameter int unsigned PAGE_BYTES = fipl_pkg::PAGE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fipl_pkg::dp_cmd_t   cmd,
	output fipl_pkg::dp_status_t status,
	input  logic [1:0]          req_type,
	input  logic                frame_is_data,
	input  logic [7:0]          frame_length,
	input  logic [7:0]          data_byte,
	input  logic [15:0]         max_image_bytes,
	input  logic                out_ready,
	output logic                out_valid,
	output fipl_pkg::kind_t     out_kind,
	output logic                out_ans,
	output fipl_pkg::phase_t    out_code,
	output logic [15:0]         out_addr,
	output logic [15:0]         out_word,
	output logic                out_last
);

	localparam int unsigned WORDS  = (PAGE_BYTES + 1) / 2;
	localparam int unsigned WORD_W = $clog2(WORDS);
	localparam int unsigned FILL_W = $clog2(PAGE_BYTES + 1);

	// latched item
	logic [1:0]  req_q;
	logic        data_q;
	logic [7:0]  flen_q;
	logic [7:0]  byte_q;

	fipl_pkg::phase_t phase_q, phase_d;
	logic [15:0]       image_size_q, size_d;
	logic [15:0]       bytes_rcvd_q, br_d;
	logic [15:0]       page_base_q;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [7:0]        size_low_q, low_d;
	logic [7:0]        bif_q, bif_d, bif_inc;
	logic              ferr_q, ferr_d;
	logic [WORDS-1:0]  valid_lo_q, valid_hi_q;
	logic [WORD_W-1:0] word_q;

	fipl_pkg::outcome_t outcome;
	fipl_pkg::kind_t    r_kind;
	logic               r_ans;
	fipl_pkg::phase_t   r_code;
	logic               store, preset;

	logic              out_free, load;
	logic              last_word;
	logic [WORD_W-1:0] widx;
	logic [7:0]        rd_lo, rd_hi, lo_b, hi_b;

	assign widx      = fill_q[WORD_W:1];
	assign last_word = (word_q == WORD_W'(WORDS - 1));
	assign out_free  = !out_valid || out_ready;
	assign bif_inc   = (bif_q == 8'hFF) ? bif_q : bif_q + 8'd1;

	assign status.outcome   = outcome;
	assign status.last_word = last_word;
	assign status.out_free  = out_free;

	always_comb begin
		outcome = fipl_pkg::OC_NONE;
		r_kind  = fipl_pkg::K_ACK;
		r_ans   = 1'b0;
		r_code  = fipl_pkg::PH_IDLE;
		phase_d = phase_q;
		size_d  = image_size_q;
		br_d    = bytes_rcvd_q;
		fill_d  = fill_q;
		low_d   = size_low_q;
		bif_d   = bif_q;
		ferr_d  = ferr_q;
		store   = 1'b0;
		preset  = 1'b0;
		case (req_q)
			fipl_pkg::REQ_START: begin
				outcome = fipl_pkg::OC_ONE;
				r_ans   = 1'b1;
				r_code  = fipl_pkg::PH_READY;
				phase_d = fipl_pkg::PH_READY;
				bif_d   = 8'd0;
				ferr_d  = 1'b0;
			end
			fipl_pkg::REQ_BYTE: begin
				if (data_q) begin
					bif_d = bif_inc;
					if (phase_q == fipl_pkg::PH_READY) begin
						// size frame: low byte first
						if (bif_inc == 8'd1) begin
							low_d = byte_q;
						end else if (bif_inc == 8'd2) begin
							size_d = {byte_q, size_low_q};
						end
					end else if (phase_q == fipl_pkg::PH_RECEIVING && !ferr_q) begin
						if (bytes_rcvd_q >= image_size_q) begin
							// overrun past image size
							outcome = fipl_pkg::OC_ONE;
							r_kind  = fipl_pkg::K_NACK;
							r_code  = fipl_pkg::PH_RECEIVING;
							phase_d = fipl_pkg::PH_IDLE;
							ferr_d  = 1'b1;
						end else begin
							store  = 1'b1;
							fill_d = fill_q + FILL_W'(1);
							br_d   = bytes_rcvd_q + 16'd1;
							if (fill_d >= FILL_W'(PAGE_BYTES) || br_d == image_size_q) begin
								outcome = fipl_pkg::OC_DUMP;
							end
						end
					end
				end
			end
			fipl_pkg::REQ_END: begin
				if (data_q) begin
					bif_d = 8'd0;
					if (ferr_q) begin
						ferr_d = 1'b0;
					end else begin
						case (phase_q)
							fipl_pkg::PH_READY: begin
								outcome = fipl_pkg::OC_ONE;
								r_code  = fipl_pkg::PH_READY;
								if (flen_q != 8'd2 || bif_q != 8'd2 || image_size_q == 16'd0 ||
									image_size_q > max_image_bytes) begin
									r_kind  = fipl_pkg::K_NACK;
									phase_d = fipl_pkg::PH_IDLE;
								end else begin
									br_d    = 16'd0;
									preset  = 1'b1;
									phase_d = fipl_pkg::PH_RECEIVING;
								end
							end
							fipl_pkg::PH_RECEIVING: begin
								r_code = fipl_pkg::PH_RECEIVING;
								if (bytes_rcvd_q == image_size_q) begin
									outcome = fipl_pkg::OC_PAIR;
									phase_d = fipl_pkg::PH_FINISHED;
								end else begin
									outcome = fipl_pkg::OC_ONE;
								end
							end
							default: begin
								// idle or finished
								outcome = fipl_pkg::OC_ONE;
								r_kind  = fipl_pkg::K_NACK;
								r_code  = phase_q;
							end
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q  <= req_type;
			data_q <= frame_is_data;
			flen_q <= frame_length;
			byte_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= fipl_pkg::PH_IDLE;
			image_size_q <= 16'd0;
			bytes_rcvd_q <= 16'd0;
			page_base_q  <= 16'd0;
			fill_q       <= '0;
			size_low_q   <= 8'd0;
			bif_q        <= 8'd0;
			ferr_q       <= 1'b0;
			valid_lo_q   <= '0;
			valid_hi_q   <= '0;
			word_q       <= '0;
		end else begin
			if (cmd.commit) begin
				phase_q      <= phase_d;
				image_size_q <= size_d;
				bytes_rcvd_q <= br_d;
				fill_q       <= fill_d;
				size_low_q   <= low_d;
				bif_q        <= bif_d;
				ferr_q       <= ferr_d;
				if (store) begin
					if (fill_q[0]) begin
						valid_hi_q[widx] <= 1'b1;
					end else begin
						valid_lo_q[widx] <= 1'b1;
					end
				end
				if (preset) begin
					page_base_q <= fipl_pkg::APP_START;
					fill_q      <= '0;
					valid_lo_q  <= '0;
					valid_hi_q  <= '0;
				end
			end
			if (cmd.load_word) begin
				if (last_word) begin
					// page written out, back to erased
					page_base_q <= page_base_q + 16'(PAGE_BYTES);
					fill_q      <= '0;
					valid_lo_q  <= '0;
					valid_hi_q  <= '0;
					word_q      <= '0;
				end else begin
					word_q <= word_q + WORD_W'(1);
				end
			end
		end
	end

	fipl_ram #(.WIDTH(8), .DEPTH(WORDS)) u_bank_lo (
		.clk   (clk),
		.we    (cmd.commit && store && !fill_q[0]),
		.waddr (widx),
		.wdata (byte_q),
		.raddr (word_q),
		.rdata (rd_lo)
	);

	fipl_ram #(.WIDTH(8), .DEPTH(WORDS)) u_bank_hi (
		.clk   (clk),
		.we    (cmd.commit && store && fill_q[0]),
		.waddr (widx),
		.wdata (byte_q),
		.raddr (word_q),
		.rdata (rd_hi)
	);

	assign lo_b = valid_lo_q[word_q] ? rd_lo : fipl_pkg::ERASED_BYTE;
	assign hi_b = valid_hi_q[word_q] ? rd_hi : fipl_pkg::ERASED_BYTE;

	assign load = (cmd.commit && (outcome == fipl_pkg::OC_ONE || outcome == fipl_pkg::OC_PAIR))
		|| cmd.load_final || cmd.load_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_word) begin
			out_kind <= fipl_pkg::K_FLASH;
			out_ans  <= 1'b0;
			out_code <= fipl_pkg::PH_IDLE;
			out_addr <= page_base_q + 16'({word_q, 1'b0});
			out_word <= {hi_b, lo_b};
			out_last <= last_word;
		end else if (cmd.load_final) begin
			out_kind <= fipl_pkg::K_FINAL;
			out_ans  <= 1'b0;
			out_code <= fipl_pkg::PH_FINISHED;
			out_addr <= 16'd0;
			out_word <= 16'd0;
			out_last <= 1'b1;
		end else if (load) begin
			out_kind <= r_kind;
			out_ans  <= r_ans;
			out_code <= r_code;
			out_addr <= 16'd0;
			out_word <= 16'd0;
			out_last <= (outcome == fipl_pkg::OC_ONE);
		end
	end

endmodule

// File: rtl/core/fipl_ctrl.sv
// ----------------------------------------------------------------------------
// fipl_ctrl
// sequencer: takes an item, commits it and walks the page dump
// ----------------------------------------------------------------------------
module fipl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  fipl_pkg::dp_status_t status,
	output fipl_pkg::dp_cmd_t    cmd
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_FINAL = 5'b00100,
		ST_RD    = 5'b01000,
		ST_WR    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d        = state_q;
		cmd.accept     = 1'b0;
		cmd.commit     = 1'b0;
		cmd.load_final = 1'b0;
		cmd.load_word  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.outcome)
					fipl_pkg::OC_NONE: begin
						cmd.commit = 1'b1;
						state_d    = ST_IDLE;
					end
					fipl_pkg::OC_ONE: begin
						if (status.out_free) begin
							cmd.commit = 1'b1;
							state_d    = ST_IDLE;
						end
					end
					fipl_pkg::OC_PAIR: begin
						if (status.out_free) begin
							cmd.commit = 1'b1;
							state_d    = ST_FINAL;
						end
					end
					default: begin
						// byte goes into the store, then dump the page
						cmd.commit = 1'b1;
						state_d    = ST_RD;
					end
				endcase
			end
			ST_FINAL: begin
				if (status.out_free) begin
					cmd.load_final = 1'b1;
					state_d        = ST_IDLE;
				end
			end
			ST_RD: begin
				state_d = ST_WR;
			end
			ST_WR: begin
				if (status.out_free) begin
					cmd.load_word = 1'b1;
					state_d       = status.last_word ? ST_IDLE : ST_RD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/firmware_image_page_loader_core.sv
// ----------------------------------------------------------------------------
// firmware_image_page_loader_core
// firmware download sequencer with page store and flash word output
// ----------------------------------------------------------------------------
// an item is taken, then committed in the exec state, which waits for a free result
// register if the item gives an ack or nack; that result is registered on commit
// a page-completing byte holds the input while the page is dumped word by word:
// each flash word needs one registered read of the two byte banks
// reset: phase idle, counters zero, page store reads erased, no result pending
module firmware_image_page_loader_core #(
	parameter int unsigned PAGE_BYTES = fipl_pkg::PAGE_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	fipl_item_if.sink     item,
	fipl_result_if.source result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic [15:0]          max_q;
	fipl_pkg::dp_cmd_t    cmd;
	fipl_pkg::dp_status_t status;
	fipl_pkg::kind_t      out_kind;
	fipl_pkg::phase_t     out_code;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == fipl_pkg::REG_MAX_IMAGE) ? {16'd0, max_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= fipl_pkg::MAX_IMAGE_DEF;
		end else if (psel && penable && pwrite && paddr[2] == fipl_pkg::REG_MAX_IMAGE) begin
			max_q <= pwdata[15:0];
		end
	end

	fipl_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.status     (status),
		.cmd        (cmd)
	);

	fipl_datapath #(.PAGE_BYTES(PAGE_BYTES)) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.req_type        (item.req_type),
		.frame_is_data   (item.frame_is_data),
		.frame_length    (item.frame_length),
		.data_byte       (item.data_byte),
		.max_image_bytes (max_q),
		.out_ready       (result.ready),
		.out_valid       (result.valid),
		.out_kind        (out_kind),
		.out_ans         (result.answers_request),
		.out_code        (out_code),
		.out_addr        (result.flash_address),
		.out_word        (result.flash_word),
		.out_last        (result.last)
	);

	assign result.resp_kind  = out_kind;
	assign result.state_code = out_code;

	// one item at a time: no second transaction straight after one is taken
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("item taken while previous one still in progress");

	// flash writes carry no phase code and never answer a request
	a_flash_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.resp_kind == fipl_pkg::K_FLASH |->
		result.state_code == fipl_pkg::PH_IDLE && !result.answers_request)
		else $error("flash write with status fields set");

	// a nack always closes the item that caused it
	a_nack_last: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.resp_kind == fipl_pkg::K_NACK |-> result.last)
		else $error("nack not marked last");

	// a final ack follows an ack of the same item
	a_final_after_ack: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && result.resp_kind == fipl_pkg::K_ACK &&
		!result.last |=> result.resp_kind == fipl_pkg::K_FINAL || !result.valid)
		else $error("ack without final ack behind it");

endmodule
